FILE: rtl/rcs_pkg.sv
// shared types, constants and control store of the rangefinder command sequencer
`timescale 1ns / 1ps

package rcs_pkg;

	localparam int FRAME_DEPTH = 32;
	localparam int FI_W = $clog2(FRAME_DEPTH);
	localparam int IX_W = FI_W + 1;
	localparam int VALUE_START = 5;
	localparam int MAX_LEN_DIGIT = 9;
	localparam int HEAD_N = VALUE_START + MAX_LEN_DIGIT;

	localparam int UPC_W = 5;
	localparam int TA_W = 7;
	localparam int CNT_W = 5;

	// input item kinds
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// result kinds
	localparam logic [2:0] K_TX = 3'd0;
	localparam logic [2:0] K_DIST = 3'd1;
	localparam logic [2:0] K_PERR = 3'd2;
	localparam logic [2:0] K_MISM = 3'd3;
	localparam logic [2:0] K_BUSY = 3'd4;
	localparam logic [2:0] K_DONE = 3'd5;

	// parse error codes
	localparam logic [2:0] E_NONE = 3'd0;
	localparam logic [2:0] E_DEVICE = 3'd1;
	localparam logic [2:0] E_PREFIX = 3'd2;
	localparam logic [2:0] E_LEN = 3'd3;
	localparam logic [2:0] E_SHORT = 3'd4;
	localparam logic [2:0] E_VALUE = 3'd5;

	// sequence phases
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_LAS = 3'd1;
	localparam logic [2:0] PH_RG_INIT = 3'd2;
	localparam logic [2:0] PH_STRG = 3'd3;
	localparam logic [2:0] PH_RG_EN = 3'd4;
	localparam logic [2:0] PH_MEAS = 3'd5;
	localparam logic [2:0] PH_S0 = 3'd6;
	localparam logic [2:0] PH_P0 = 3'd7;

	// sequencer events
	localparam logic [1:0] EV_BUSY = 2'd0;
	localparam logic [1:0] EV_START = 2'd1;
	localparam logic [1:0] EV_FRAME = 2'd2;

	// configuration registers
	localparam logic REG_ATTEMPT_LIMIT = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;
	localparam logic [7:0] ATTEMPT_RESET = 8'd1;
	localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

	localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

	// characters
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_M = 8'h6D;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;

	// command and reply text, no terminators
	localparam int TXT_LEN = 94;
	localparam logic [8*TXT_LEN-1:0] TXT = {"<mALas>", "<RDRG><jzmode><STRG055><quitjz>",
		"<RG055>", "<STRG055>", "<RDRG><mAo>", "<mAm>", "<mAs>", "<m10s0>", "<mAp>",
		"<m10p0>"};

	localparam logic [TA_W-1:0] S_INIT_B = 7'd0;
	localparam logic [TA_W-1:0] S_SETUP_B = 7'd7;
	localparam logic [TA_W-1:0] S_RG_B = 7'd38;
	localparam logic [TA_W-1:0] S_STRG_B = 7'd45;
	localparam logic [TA_W-1:0] S_EN_B = 7'd54;
	localparam logic [TA_W-1:0] S_MEAS_B = 7'd65;
	localparam logic [TA_W-1:0] S_STOP_B = 7'd70;
	localparam logic [TA_W-1:0] S_S0_B = 7'd75;
	localparam logic [TA_W-1:0] S_OFF_B = 7'd82;
	localparam logic [TA_W-1:0] S_P0_B = 7'd87;

	localparam logic [CNT_W-1:0] L_INIT = 5'd7;
	localparam logic [CNT_W-1:0] L_SETUP = 5'd31;
	localparam logic [CNT_W-1:0] L_RG = 5'd7;
	localparam logic [CNT_W-1:0] L_STRG = 5'd9;
	localparam logic [CNT_W-1:0] L_EN = 5'd11;
	localparam logic [CNT_W-1:0] L_MEAS = 5'd5;
	localparam logic [CNT_W-1:0] L_STOP = 5'd5;
	localparam logic [CNT_W-1:0] L_S0 = 5'd7;
	localparam logic [CNT_W-1:0] L_OFF = 5'd5;
	localparam logic [CNT_W-1:0] L_P0 = 5'd7;

	typedef enum logic [2:0] {
		U_SEND,
		U_CHECK,
		U_PARSE,
		U_RETRY,
		U_EMIT,
		U_END
	} uop_t;

	typedef struct packed {
		uop_t uop;
		logic [TA_W-1:0] base;
		logic [CNT_W-1:0] len;
		logic [2:0] kind;
		logic lst;
		logic opn;
		logic setph;
		logic [2:0] nph;
		logic [UPC_W-1:0] tgt;
	} cw_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] tx_byte;
		logic [30:0] distance;
		logic [2:0] error_code;
		logic last;
	} res_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [2:0] code;
		logic [30:0] value;
	} par_res_t;

	// program entry points
	localparam logic [UPC_W-1:0] UA_BUSY = 5'd0;
	localparam logic [UPC_W-1:0] UA_START = 5'd2;
	localparam logic [UPC_W-1:0] UA_LAS = 5'd4;
	localparam logic [UPC_W-1:0] UA_RGI = 5'd6;
	localparam logic [UPC_W-1:0] UA_STRG = 5'd8;
	localparam logic [UPC_W-1:0] UA_RGE = 5'd11;
	localparam logic [UPC_W-1:0] UA_MEAS = 5'd14;
	localparam logic [UPC_W-1:0] UA_STOP = 5'd18;
	localparam logic [UPC_W-1:0] UA_S0 = 5'd20;
	localparam logic [UPC_W-1:0] UA_P0 = 5'd23;

	function automatic logic [7:0] txt_byte(input logic [TA_W-1:0] a);
		logic [7:0] b;
		b = 8'd0;
		if (int'(a) < TXT_LEN) begin
			b = TXT[(TXT_LEN - 1 - int'(a)) * 8 +: 8];
		end
		return b;
	endfunction

	function automatic cw_t mk(input uop_t u, input logic [TA_W-1:0] b,
		input logic [CNT_W-1:0] l, input logic [2:0] k, input logic ls, input logic op,
		input logic sp, input logic [2:0] ph, input logic [UPC_W-1:0] t);
		cw_t w;
		w.uop = u;
		w.base = b;
		w.len = l;
		w.kind = k;
		w.lst = ls;
		w.opn = op;
		w.setph = sp;
		w.nph = ph;
		w.tgt = t;
		return w;
	endfunction

	function automatic cw_t ucode(input logic [UPC_W-1:0] a);
		cw_t w;
		unique case (a)
			UA_BUSY:        w = mk(U_EMIT, S_INIT_B, L_INIT, K_BUSY, 1'b1, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_BUSY + 5'd1: w = mk(U_END, S_INIT_B, L_INIT, K_TX, 1'b0, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_START:       w = mk(U_SEND, S_INIT_B, L_INIT, K_TX, 1'b1, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_START + 5'd1: w = mk(U_END, S_INIT_B, L_INIT, K_TX, 1'b0, 1'b1, 1'b1,
						PH_LAS, UA_BUSY);
			UA_LAS:         w = mk(U_SEND, S_SETUP_B, L_SETUP, K_TX, 1'b1, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_LAS + 5'd1:  w = mk(U_END, S_INIT_B, L_INIT, K_TX, 1'b0, 1'b1, 1'b1,
						PH_RG_INIT, UA_BUSY);
			UA_RGI:         w = mk(U_CHECK, S_RG_B, L_RG, K_TX, 1'b1, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_RGI + 5'd1:  w = mk(U_END, S_INIT_B, L_INIT, K_TX, 1'b0, 1'b1, 1'b1,
						PH_STRG, UA_BUSY);
			UA_STRG:        w = mk(U_CHECK, S_STRG_B, L_STRG, K_TX, 1'b0, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_STRG + 5'd1: w = mk(U_SEND, S_EN_B, L_EN, K_TX, 1'b1, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_STRG + 5'd2: w = mk(U_END, S_INIT_B, L_INIT, K_TX, 1'b0, 1'b1, 1'b1,
						PH_RG_EN, UA_BUSY);
			UA_RGE:         w = mk(U_CHECK, S_RG_B, L_RG, K_TX, 1'b0, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_RGE + 5'd1:  w = mk(U_SEND, S_MEAS_B, L_MEAS, K_TX, 1'b1, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_RGE + 5'd2:  w = mk(U_END, S_INIT_B, L_INIT, K_TX, 1'b0, 1'b1, 1'b1,
						PH_MEAS, UA_BUSY);
			UA_MEAS:        w = mk(U_PARSE, S_INIT_B, L_INIT, K_TX, 1'b0, 1'b0, 1'b0,
						PH_IDLE, UA_STOP);
			UA_MEAS + 5'd1: w = mk(U_RETRY, S_INIT_B, L_INIT, K_TX, 1'b0, 1'b0, 1'b0,
						PH_IDLE, UA_STOP);
			UA_MEAS + 5'd2: w = mk(U_SEND, S_MEAS_B, L_MEAS, K_TX, 1'b1, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_MEAS + 5'd3: w = mk(U_END, S_INIT_B, L_INIT, K_TX, 1'b0, 1'b1, 1'b0,
						PH_MEAS, UA_BUSY);
			UA_STOP:        w = mk(U_SEND, S_STOP_B, L_STOP, K_TX, 1'b1, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_STOP + 5'd1: w = mk(U_END, S_INIT_B, L_INIT, K_TX, 1'b0, 1'b1, 1'b1,
						PH_S0, UA_BUSY);
			UA_S0:          w = mk(U_CHECK, S_S0_B, L_S0, K_TX, 1'b0, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_S0 + 5'd1:   w = mk(U_SEND, S_OFF_B, L_OFF, K_TX, 1'b1, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_S0 + 5'd2:   w = mk(U_END, S_INIT_B, L_INIT, K_TX, 1'b0, 1'b1, 1'b1,
						PH_P0, UA_BUSY);
			UA_P0:          w = mk(U_CHECK, S_P0_B, L_P0, K_TX, 1'b0, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_P0 + 5'd1:   w = mk(U_EMIT, S_INIT_B, L_INIT, K_DONE, 1'b1, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
			UA_P0 + 5'd2:   w = mk(U_END, S_INIT_B, L_INIT, K_TX, 1'b0, 1'b0, 1'b1,
						PH_IDLE, UA_BUSY);
			default:        w = mk(U_END, S_INIT_B, L_INIT, K_TX, 1'b0, 1'b0, 1'b0,
						PH_IDLE, UA_BUSY);
		endcase
		return w;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

FILE: rtl/rcs_frame.sv
// reply frame buffer with fill count and millisecond timeout counter
`timescale 1ns / 1ps

module rcs_frame (
	input  logic clk,
	input  logic arst_n,
	input  logic byte_req,
	input  logic [7:0] rx_byte,
	input  logic tick_req,
	input  logic open_req,
	input  logic [15:0] timeout,
	input  logic [rcs_pkg::FI_W-1:0] rd_addr,
	output logic [7:0] rd_data,
	output logic [rcs_pkg::HEAD_N-1:0][7:0] head,
	output logic frame_end
);

	logic [7:0] store_q [rcs_pkg::FRAME_DEPTH];
	logic [rcs_pkg::FI_W-1:0] fill_q;
	logic [15:0] elapsed_q;
	logic room;

	assign room = fill_q < rcs_pkg::FI_W'(rcs_pkg::FRAME_DEPTH - 1);

	always_ff @(posedge clk) begin
		if (byte_req && room) begin
			store_q[fill_q] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			elapsed_q <= '0;
		end else if (open_req) begin
			fill_q <= '0;
			elapsed_q <= '0;
		end else begin
			if (byte_req && room) begin
				fill_q <= fill_q + rcs_pkg::FI_W'(1);
			end
			if (tick_req && (elapsed_q < timeout)) begin
				elapsed_q <= elapsed_q + 16'd1;
			end
		end
	end

	// entries at or past the fill read as zero
	assign rd_data = (rd_addr < fill_q) ? store_q[rd_addr] : 8'd0;

	always_comb begin
		for (int k = 0; k < rcs_pkg::HEAD_N; k++) begin
			head[k] = (rcs_pkg::FI_W'(k) < fill_q) ? store_q[k] : 8'd0;
		end
	end

	assign frame_end = (byte_req && (!room || (rx_byte == rcs_pkg::CH_GT)
			|| (fill_q == rcs_pkg::FI_W'(rcs_pkg::FRAME_DEPTH - 2))))
		|| (tick_req && (elapsed_q >= timeout));

endmodule

FILE: rtl/rcs_parse.sv
// reply value parser, one frame byte per cycle
`timescale 1ns / 1ps

module rcs_parse (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic ack,
	input  logic [rcs_pkg::HEAD_N-1:0][7:0] head,
	input  logic [7:0] rd_data,
	output logic [rcs_pkg::FI_W-1:0] rd_addr,
	output logic act,
	output rcs_pkg::par_res_t res
);

	localparam logic [1:0] PS_IDLE = 2'd0;
	localparam logic [1:0] PS_SKIP = 2'd1;
	localparam logic [1:0] PS_DIG = 2'd2;
	localparam logic [1:0] PS_DONE = 2'd3;

	logic [1:0] st_q;
	logic [rcs_pkg::IX_W-1:0] idx_q;
	logic neg_q;
	logic [30:0] val_q;
	logic [2:0] code_q;

	logic [2:0] hcode;
	logic [3:0] len;
	logic short_val;
	logic in_rng;
	logic [7:0] b;
	logic [34:0] prod;
	logic sat;

	// header checks on the fixed leading bytes
	always_comb begin
		len = head[2][3:0];
		short_val = 1'b0;
		for (int j = 0; j < rcs_pkg::MAX_LEN_DIGIT; j++) begin
			if ((4'(j) < len) && (head[rcs_pkg::VALUE_START + j] == 8'd0)) begin
				short_val = 1'b1;
			end
		end
		priority if ((head[0] == rcs_pkg::CH_LT) && (head[1] == rcs_pkg::CH_0)
				&& (head[2] == rcs_pkg::CH_E)) begin
			hcode = rcs_pkg::E_DEVICE;
		end else if ((head[0] != rcs_pkg::CH_LT) || (head[1] != rcs_pkg::CH_M)) begin
			hcode = rcs_pkg::E_PREFIX;
		end else if (!rcs_pkg::is_digit(head[2])) begin
			hcode = rcs_pkg::E_LEN;
		end else if (short_val) begin
			hcode = rcs_pkg::E_SHORT;
		end else begin
			hcode = rcs_pkg::E_NONE;
		end
	end

	assign in_rng = idx_q < rcs_pkg::IX_W'(rcs_pkg::FRAME_DEPTH);
	assign rd_addr = idx_q[rcs_pkg::FI_W-1:0];
	assign b = in_rng ? rd_data : 8'd0;
	assign prod = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0} + {31'd0, b[3:0]};
	assign sat = prod > {4'd0, rcs_pkg::DIST_MAX};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PS_IDLE;
		end else begin
			unique case (st_q)
				PS_IDLE: if (start) begin
					st_q <= (hcode != rcs_pkg::E_NONE) ? PS_DONE : PS_SKIP;
				end
				PS_SKIP: if (!rcs_pkg::is_space(b)) begin
					st_q <= PS_DIG;
				end
				PS_DIG: if (!(in_rng && rcs_pkg::is_digit(b))) begin
					st_q <= PS_DONE;
				end
				PS_DONE: if (ack) begin
					st_q <= PS_IDLE;
				end
				default: st_q <= PS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			PS_IDLE: begin
				idx_q <= rcs_pkg::IX_W'(rcs_pkg::VALUE_START);
				neg_q <= 1'b0;
				val_q <= '0;
				code_q <= hcode;
			end
			PS_SKIP: begin
				if (rcs_pkg::is_space(b)) begin
					idx_q <= idx_q + rcs_pkg::IX_W'(1);
				end else if ((b == rcs_pkg::CH_MINUS) || (b == rcs_pkg::CH_PLUS)) begin
					neg_q <= (b == rcs_pkg::CH_MINUS);
					idx_q <= idx_q + rcs_pkg::IX_W'(1);
				end
			end
			PS_DIG: begin
				if (in_rng && rcs_pkg::is_digit(b)) begin
					val_q <= sat ? rcs_pkg::DIST_MAX : prod[30:0];
					idx_q <= idx_q + rcs_pkg::IX_W'(1);
				end else begin
					code_q <= (neg_q || (val_q == 31'd0)) ? rcs_pkg::E_VALUE : rcs_pkg::E_NONE;
				end
			end
			PS_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign act = (st_q == PS_SKIP) || (st_q == PS_DIG);
	assign res.busy = st_q != PS_IDLE;
	assign res.done = st_q == PS_DONE;
	assign res.code = code_q;
	assign res.value = val_q;

endmodule

FILE: rtl/rcs_seq.sv
// microcoded sequencer: control store walk, byte streaming, compare and result register
`timescale 1ns / 1ps

module rcs_seq (
	input  logic clk,
	input  logic arst_n,
	input  logic ev_valid,
	input  logic [1:0] ev_kind,
	input  logic [7:0] attempt_limit,
	output logic run,
	output logic [2:0] phase,
	output logic [rcs_pkg::FI_W-1:0] frame_rd_addr,
	input  logic [7:0] frame_rd_data,
	output logic open_req,
	output logic par_start,
	output logic par_ack,
	input  rcs_pkg::par_res_t par,
	output logic out_valid,
	input  logic out_ready,
	output rcs_pkg::res_t out_res
);

	logic run_q;
	logic [rcs_pkg::UPC_W-1:0] upc_q;
	logic [rcs_pkg::CNT_W-1:0] cnt_q;
	logic [2:0] phase_q;
	logic [7:0] att_q;
	logic ov_q;
	rcs_pkg::res_t res_q;

	rcs_pkg::cw_t cw;
	logic can_emit;
	logic [7:0] txb;
	logic [7:0] want;
	logic mism;
	logic last_byte;
	logic [7:0] att_n;
	logic [rcs_pkg::UPC_W-1:0] entry;

	logic emit;
	rcs_pkg::res_t r;
	logic [rcs_pkg::UPC_W-1:0] upc_n;
	logic [rcs_pkg::CNT_W-1:0] cnt_n;
	logic fin;
	logic ph_we;
	logic att_we;

	assign cw = rcs_pkg::ucode(upc_q);
	assign can_emit = !ov_q || out_ready;
	assign txb = rcs_pkg::txt_byte(cw.base + rcs_pkg::TA_W'(cnt_q));
	assign want = (cnt_q < cw.len) ? txb : 8'd0;
	assign frame_rd_addr = rcs_pkg::FI_W'(cnt_q);
	assign mism = want != frame_rd_data;
	assign last_byte = cnt_q == (cw.len - rcs_pkg::CNT_W'(1));
	assign att_n = (att_q == 8'hFF) ? att_q : att_q + 8'd1;

	always_comb begin
		unique case (phase_q)
			rcs_pkg::PH_LAS:     entry = rcs_pkg::UA_LAS;
			rcs_pkg::PH_RG_INIT: entry = rcs_pkg::UA_RGI;
			rcs_pkg::PH_STRG:    entry = rcs_pkg::UA_STRG;
			rcs_pkg::PH_RG_EN:   entry = rcs_pkg::UA_RGE;
			rcs_pkg::PH_MEAS:    entry = rcs_pkg::UA_MEAS;
			rcs_pkg::PH_S0:      entry = rcs_pkg::UA_S0;
			rcs_pkg::PH_P0:      entry = rcs_pkg::UA_P0;
			default:             entry = rcs_pkg::UA_BUSY;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		r = '0;
		upc_n = upc_q;
		cnt_n = cnt_q;
		fin = 1'b0;
		open_req = 1'b0;
		ph_we = 1'b0;
		att_we = 1'b0;
		par_start = 1'b0;
		par_ack = 1'b0;
		if (run_q) begin
			unique case (cw.uop)
				rcs_pkg::U_SEND: if (can_emit) begin
					emit = 1'b1;
					r.kind = rcs_pkg::K_TX;
					r.tx_byte = txb;
					r.last = cw.lst && last_byte;
					if (last_byte) begin
						cnt_n = '0;
						upc_n = upc_q + rcs_pkg::UPC_W'(1);
					end else begin
						cnt_n = cnt_q + rcs_pkg::CNT_W'(1);
					end
				end
				rcs_pkg::U_CHECK: begin
					if (mism) begin
						if (can_emit) begin
							emit = 1'b1;
							r.kind = rcs_pkg::K_MISM;
							r.last = cw.lst;
							cnt_n = '0;
							upc_n = upc_q + rcs_pkg::UPC_W'(1);
						end
					end else if (cnt_q == cw.len) begin
						cnt_n = '0;
						upc_n = upc_q + rcs_pkg::UPC_W'(1);
					end else begin
						cnt_n = cnt_q + rcs_pkg::CNT_W'(1);
					end
				end
				rcs_pkg::U_PARSE: begin
					par_start = !par.busy;
					if (par.done && can_emit) begin
						emit = 1'b1;
						par_ack = 1'b1;
						r.last = cw.lst;
						if (par.code == rcs_pkg::E_NONE) begin
							r.kind = rcs_pkg::K_DIST;
							r.distance = par.value;
							upc_n = cw.tgt;
						end else begin
							r.kind = rcs_pkg::K_PERR;
							r.error_code = par.code;
							upc_n = upc_q + rcs_pkg::UPC_W'(1);
						end
					end
				end
				rcs_pkg::U_RETRY: begin
					att_we = 1'b1;
					upc_n = (att_n < attempt_limit) ? upc_q + rcs_pkg::UPC_W'(1) : cw.tgt;
				end
				rcs_pkg::U_EMIT: if (can_emit) begin
					emit = 1'b1;
					r.kind = cw.kind;
					r.last = cw.lst;
					upc_n = upc_q + rcs_pkg::UPC_W'(1);
				end
				rcs_pkg::U_END: begin
					fin = 1'b1;
					open_req = cw.opn;
					ph_we = cw.setph;
				end
				default: fin = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			upc_q <= rcs_pkg::UA_BUSY;
			cnt_q <= '0;
			phase_q <= rcs_pkg::PH_IDLE;
			att_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (ev_valid) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				unique case (ev_kind)
					rcs_pkg::EV_BUSY:  upc_q <= rcs_pkg::UA_BUSY;
					rcs_pkg::EV_START: upc_q <= rcs_pkg::UA_START;
					rcs_pkg::EV_FRAME: upc_q <= entry;
					default:           upc_q <= rcs_pkg::UA_BUSY;
				endcase
			end else begin
				if (fin) begin
					run_q <= 1'b0;
				end
				upc_q <= upc_n;
				cnt_q <= cnt_n;
			end
			if (ph_we) begin
				phase_q <= cw.nph;
			end
			if (ev_valid && (ev_kind == rcs_pkg::EV_START)) begin
				att_q <= '0;
			end else if (att_we) begin
				att_q <= att_n;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= r;
		end
	end

	assign run = run_q;
	assign phase = phase_q;
	assign out_valid = ov_q;
	assign out_res = res_q;

`ifndef ASSERT_OFF
	a_ev_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid |-> !run_q)
		else $error("event taken while a program runs");

	a_phase_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && (cw.uop != rcs_pkg::U_END)) |=> $stable(phase_q))
		else $error("phase moved outside an end step");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!run_q && !(ov_q && !out_ready)) |=> !ov_q)
		else $error("result produced while sequencer idle");

	a_end_stops: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> !run_q)
		else $error("sequencer still running after end step");
`endif

endmodule

FILE: rtl/rangefinder_command_sequencer.sv
// rangefinder command sequencer top level
// Input stream s_*: s_tuser is the item kind (start, received byte, millisecond
// tick), s_tdata carries the received byte. Result stream m_*: m_tuser is the
// result kind, m_tdata holds tx byte, distance and error code, m_tlast marks the
// final result of one input transaction. cfg_we/cfg_addr/cfg_wdata write the
// attempt limit (index 0) and the timeout in ms (index 1).
// A byte or tick that does not complete a frame is taken without running a program.
// A start, a busy reject or a completed frame runs a short program from the
// control store, whose steps send command bytes, compare reply bytes, parse the
// measured value by scanning frame positions, and finish with an end step.
// s_tready is low while a program runs. Results leave through one output
// register; when m_tready is low the program waits at its next result.
// Reset clears the phase to idle, the frame fill, attempt count and timer, and
// loads attempt limit 1 and timeout 10000.
`timescale 1ns / 1ps

module rangefinder_command_sequencer (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // rx_byte
	input  logic [1:0] s_tuser,   // op
	output logic m_tvalid,
	input  logic m_tready,
	output logic [47:0] m_tdata,  // tx_byte, distance, error_code, zero pad
	output logic [2:0] m_tuser,   // kind
	output logic m_tlast,
	input  logic cfg_we,
	input  logic cfg_addr,
	input  logic [15:0] cfg_wdata
);

	logic [7:0] limit_q;
	logic [15:0] timeout_q;

	logic acc;
	logic active;
	logic byte_req;
	logic tick_req;
	logic frame_end;
	logic ev_valid;
	logic [1:0] ev_kind;
	logic run;
	logic [2:0] phase;
	logic open_req;
	logic [rcs_pkg::FI_W-1:0] seq_rd_addr;
	logic [rcs_pkg::FI_W-1:0] par_rd_addr;
	logic [rcs_pkg::FI_W-1:0] rd_addr;
	logic [7:0] rd_data;
	logic [rcs_pkg::HEAD_N-1:0][7:0] head;
	logic par_start;
	logic par_ack;
	logic par_act;
	rcs_pkg::par_res_t par;
	rcs_pkg::res_t out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= rcs_pkg::ATTEMPT_RESET;
			timeout_q <= rcs_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				rcs_pkg::REG_ATTEMPT_LIMIT: limit_q <= cfg_wdata[7:0];
				rcs_pkg::REG_TIMEOUT:       timeout_q <= cfg_wdata;
				default:                    limit_q <= limit_q;
			endcase
		end
	end

	assign s_tready = !run;
	assign acc = s_tvalid && s_tready;
	assign active = phase != rcs_pkg::PH_IDLE;
	assign byte_req = acc && (s_tuser == rcs_pkg::OP_BYTE) && active;
	assign tick_req = acc && (s_tuser == rcs_pkg::OP_TICK) && active;

	assign ev_valid = acc && ((s_tuser == rcs_pkg::OP_START) || frame_end);
	assign ev_kind = (s_tuser == rcs_pkg::OP_START)
		? (active ? rcs_pkg::EV_BUSY : rcs_pkg::EV_START) : rcs_pkg::EV_FRAME;

	assign rd_addr = par_act ? par_rd_addr : seq_rd_addr;

	rcs_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_req  (byte_req),
		.rx_byte   (s_tdata),
		.tick_req  (tick_req),
		.open_req  (open_req),
		.timeout   (timeout_q),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.head      (head),
		.frame_end (frame_end)
	);

	rcs_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (par_start),
		.ack     (par_ack),
		.head    (head),
		.rd_data (rd_data),
		.rd_addr (par_rd_addr),
		.act     (par_act),
		.res     (par)
	);

	rcs_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.ev_valid      (ev_valid),
		.ev_kind       (ev_kind),
		.attempt_limit (limit_q),
		.run           (run),
		.phase         (phase),
		.frame_rd_addr (seq_rd_addr),
		.frame_rd_data (rd_data),
		.open_req      (open_req),
		.par_start     (par_start),
		.par_ack       (par_ack),
		.par           (par),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_res       (out_res)
	);

	assign m_tdata = {6'd0, out_res.error_code, out_res.distance, out_res.tx_byte};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule

FILE: tb/tb_top.sv
// testbench for the rangefinder command sequencer with predictor and result scoreboard
`timescale 1ns / 1ps

module tb_top;
	import rcs_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		logic typed;
		logic silent;
		logic [2:0] kind;
		logic [2:0] code;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;
	logic cfg_we;
	logic cfg_addr;
	logic [15:0] cfg_wdata;

	// sequencer state as predicted
	logic [7:0] frame_buf [0:FRAME_DEPTH-1];
	int fill;
	int elapsed;
	int tries;
	int lim;
	int tmo;
	int frames_closed;
	logic [2:0] ph;

	res_t sequencer_out_q[$];
	stim_row_t dir_tab[$];
	logic [7:0] reply_bytes[$];
	res_t head;
	int first_new;
	int live_items;
	int fails;
	int n_checked;
	int n_dist;
	int n_perr;
	int n_mism;
	int n_busy;
	bit steady;

	rangefinder_command_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic logic [7:0] fbyte(input int i);
		return (i < FRAME_DEPTH) ? frame_buf[i] : 8'h00;
	endfunction

	function automatic logic blank_char(input logic [7:0] c);
		return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (b == CH_GT)
			b = 8'h78;
		return b;
	endfunction

	function automatic stim_row_t dir_row(input logic [1:0] op, input logic [7:0] data,
		input logic typed, input logic silent, input logic [2:0] kind, input logic [2:0] code);
		stim_row_t r;
		r.op = op;
		r.data = data;
		r.typed = typed;
		r.silent = silent;
		r.kind = kind;
		r.code = code;
		return r;
	endfunction

	function automatic string reply_text(input logic [2:0] p);
		case (p)
			PH_RG_INIT, PH_RG_EN: return "<RG055>";
			PH_STRG: return "<STRG055>";
			PH_S0: return "<m10s0>";
			PH_P0: return "<m10p0>";
			default: return "<mALas>";
		endcase
	endfunction

	task automatic put_result(input logic [2:0] kind, input logic [7:0] tx,
		input logic [30:0] range_val, input logic [2:0] code);
		res_t r;
		r.kind = kind;
		r.tx_byte = tx;
		r.distance = range_val;
		r.error_code = code;
		r.last = 1'b0;
		sequencer_out_q.push_back(r);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_result(K_TX, 8'(s[i]), 31'd0, E_NONE);
	endtask

	task automatic check_text(input string want);
		logic [7:0] a;
		for (int i = 0; i <= want.len(); i++) begin
			a = (i < want.len()) ? 8'(want[i]) : 8'h00;
			if (a != fbyte(i)) begin
				put_result(K_MISM, 8'h00, 31'd0, E_NONE);
				return;
			end
			if (a == 8'h00)
				return;
		end
	endtask

	task automatic frame_open();
		for (int i = 0; i < FRAME_DEPTH; i++)
			frame_buf[i] = 8'h00;
		fill = 0;
		elapsed = 0;
	endtask

	function automatic logic [2:0] read_distance(output logic [30:0] range_val);
		int n;
		int i;
		int unsigned v;
		int unsigned dg;
		bit neg;
		range_val = 31'd0;
		v = 0;
		neg = 1'b0;
		if (fbyte(0) == CH_LT && fbyte(1) == CH_0 && fbyte(2) == CH_E)
			return E_DEVICE;
		if (fbyte(0) != CH_LT || fbyte(1) != CH_M)
			return E_PREFIX;
		if (fbyte(2) < CH_0 || fbyte(2) > CH_9)
			return E_LEN;
		n = int'(fbyte(2)) - int'(CH_0);
		for (i = 0; i < n; i++)
			if (fbyte(VALUE_START + i) == 8'h00)
				return E_SHORT;
		i = VALUE_START;
		while (i < FRAME_DEPTH && blank_char(fbyte(i)))
			i++;
		if (fbyte(i) == CH_MINUS || fbyte(i) == CH_PLUS) begin
			neg = (fbyte(i) == CH_MINUS);
			i++;
		end
		while (i < FRAME_DEPTH && fbyte(i) >= CH_0 && fbyte(i) <= CH_9) begin
			dg = int'(fbyte(i)) - int'(CH_0);
			if (v > (int'(DIST_MAX) - dg) / 10)
				v = int'(DIST_MAX);
			else
				v = v * 10 + dg;
			i++;
		end
		if (neg || v == 0)
			return E_VALUE;
		range_val = v[30:0];
		return E_NONE;
	endfunction

	task automatic frame_complete();
		logic [30:0] range_val;
		logic [2:0] code;
		frames_closed++;
		case (ph)
			PH_LAS: begin
				send_text("<RDRG><jzmode><STRG055><quitjz>");
				frame_open();
				ph = PH_RG_INIT;
			end
			PH_RG_INIT: begin
				check_text("<RG055>");
				frame_open();
				ph = PH_STRG;
			end
			PH_STRG: begin
				check_text("<STRG055>");
				send_text("<RDRG><mAo>");
				frame_open();
				ph = PH_RG_EN;
			end
			PH_RG_EN: begin
				check_text("<RG055>");
				send_text("<mAm>");
				frame_open();
				ph = PH_MEAS;
			end
			PH_MEAS: begin
				code = read_distance(range_val);
				if (code == E_NONE) begin
					put_result(K_DIST, 8'h00, range_val, E_NONE);
				end else begin
					put_result(K_PERR, 8'h00, 31'd0, code);
					if (tries < 255)
						tries++;
					if (tries < lim) begin
						send_text("<mAm>");
						frame_open();
						return;
					end
				end
				send_text("<mAs>");
				frame_open();
				ph = PH_S0;
			end
			PH_S0: begin
				check_text("<m10s0>");
				send_text("<mAp>");
				frame_open();
				ph = PH_P0;
			end
			PH_P0: begin
				check_text("<m10p0>");
				put_result(K_DONE, 8'h00, 31'd0, E_NONE);
				ph = PH_IDLE;
			end
			default: ;
		endcase
	endtask

	task automatic sequencer_step(input logic [1:0] op, input logic [7:0] rx);
		bit done;
		done = 1'b0;
		if (op == OP_START) begin
			if (ph != PH_IDLE) begin
				put_result(K_BUSY, 8'h00, 31'd0, E_NONE);
			end else begin
				tries = 0;
				send_text("<mALas>");
				frame_open();
				ph = PH_LAS;
			end
		end else if (op == OP_BYTE && ph != PH_IDLE) begin
			if (fill < FRAME_DEPTH - 1) begin
				frame_buf[fill] = rx;
				fill++;
				if (rx == CH_GT)
					done = 1'b1;
			end
			if (fill >= FRAME_DEPTH - 1)
				done = 1'b1;
		end else if (op == OP_TICK && ph != PH_IDLE) begin
			if (elapsed >= tmo)
				done = 1'b1;
			else
				elapsed++;
		end
		if (done)
			frame_complete();
	endtask

	task automatic feed_item(input logic [1:0] op, input logic [7:0] data);
		res_t tail;
		while (!steady && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		do
			@(posedge clk);
		while (!s_tready);
		if (op != OP_SPARE && (op == OP_START || ph != PH_IDLE))
			live_items++;
		first_new = sequencer_out_q.size();
		sequencer_step(op, data);
		if (sequencer_out_q.size() > first_new) begin
			tail = sequencer_out_q[sequencer_out_q.size() - 1];
			tail.last = 1'b1;
			sequencer_out_q[sequencer_out_q.size() - 1] = tail;
		end
	endtask

	task automatic feed_frame();
		int closed0;
		closed0 = frames_closed;
		foreach (reply_bytes[k]) begin
			if (frames_closed == closed0 && $urandom_range(99) < 8)
				feed_item(OP_TICK, plain_byte());
			if (frames_closed == closed0)
				feed_item(OP_BYTE, reply_bytes[k]);
		end
		while (frames_closed == closed0 && tmo <= 8)
			feed_item(OP_TICK, plain_byte());
	endtask

	task automatic send_reply();
		string t;
		int r;
		int cut;
		t = reply_text(ph);
		r = $urandom_range(99);
		reply_bytes.delete();
		for (int k = 0; k < t.len(); k++)
			reply_bytes.push_back(8'(t[k]));
		if (r >= 93) begin
			cut = $urandom_range(1, t.len() - 1);
			repeat (cut)
				reply_bytes.delete(reply_bytes.size() - 1);
			reply_bytes.push_back(CH_GT);
		end else if (r >= 87) begin
			feed_item(OP_START, plain_byte());
			feed_item(OP_SPARE, plain_byte());
		end else if (r >= 75) begin
			reply_bytes.delete();
			repeat ($urandom_range(4))
				reply_bytes.push_back(plain_byte());
			if (tmo > 8)
				reply_bytes.push_back(CH_GT);
		end else if (r >= 65) begin
			reply_bytes.delete();
			repeat (FRAME_DEPTH - 1)
				reply_bytes.push_back(plain_byte());
		end else if (r >= 50) begin
			reply_bytes[$urandom_range(t.len() - 1)] = 8'($urandom_range(255));
		end
		feed_frame();
	endtask

	task automatic send_reading();
		int r;
		int nd;
		int cnt;
		int lenv;
		r = $urandom_range(99);
		reply_bytes.delete();
		reply_bytes.push_back(CH_LT);
		if (r < 8) begin
			reply_bytes.push_back(CH_0);
			reply_bytes.push_back(CH_E);
		end else if (r < 16) begin
			reply_bytes[0] = plain_byte();
			reply_bytes.push_back(plain_byte());
			reply_bytes.push_back(plain_byte());
		end else if (r < 24) begin
			reply_bytes.push_back(CH_M);
			reply_bytes.push_back(8'(8'h41 + $urandom_range(25)));
		end else begin
			reply_bytes.push_back(CH_M);
			reply_bytes.push_back(CH_0);
		end
		repeat (2)
			reply_bytes.push_back(8'(8'h61 + $urandom_range(25)));
		repeat ($urandom_range(2))
			reply_bytes.push_back(($urandom_range(99) < 50) ? CH_SP : 8'($urandom_range(9, 13)));
		if ($urandom_range(99) < 10)
			reply_bytes.push_back(CH_MINUS);
		else if ($urandom_range(99) < 12)
			reply_bytes.push_back(CH_PLUS);
		nd = ($urandom_range(99) < 10) ? $urandom_range(10, 22) : $urandom_range(6);
		repeat (nd)
			reply_bytes.push_back(8'(CH_0 + $urandom_range(9)));
		if ($urandom_range(99) < 8)
			reply_bytes.insert($urandom_range(3, reply_bytes.size()), 8'h00);
		reply_bytes.push_back(CH_GT);
		if (r >= 24) begin
			cnt = reply_bytes.size() - VALUE_START;
			if (cnt < 0 || $urandom_range(99) < 15)
				lenv = $urandom_range(9);
			else
				lenv = $urandom_range((cnt > 9) ? 9 : cnt);
			reply_bytes[2] = 8'(CH_0 + lenv);
		end
		feed_frame();
	endtask

	task automatic random_phase(input int n);
		int start;
		start = live_items;
		while (live_items - start < n) begin
			if (ph == PH_IDLE) begin
				if ($urandom_range(99) < 85)
					feed_item(OP_START, plain_byte());
				else
					feed_item(2'($urandom_range(1, 3)), plain_byte());
			end else if (ph == PH_MEAS) begin
				send_reading();
			end else begin
				send_reply();
			end
		end
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (sequencer_out_q.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (64)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ATTEMPT_LIMIT)
			lim = int'(val[7:0]);
		else
			tmo = int'(val);
		@(posedge clk);
	endtask

	always @(posedge clk)
		m_tready <= steady || ($urandom_range(99) >= 24);

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			n_checked++;
			case (m_tuser)
				K_DIST: n_dist++;
				K_PERR: n_perr++;
				K_MISM: n_mism++;
				K_BUSY: n_busy++;
				default: ;
			endcase
			if (sequencer_out_q.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("result transaction with nothing awaited: kind %0d tdata %h",
						m_tuser, m_tdata);
			end else begin
				head = sequencer_out_q.pop_front();
				if (m_tuser !== head.kind || m_tdata[7:0] !== head.tx_byte ||
					m_tdata[38:8] !== head.distance || m_tdata[41:39] !== head.error_code ||
					m_tlast !== head.last) begin
					fails++;
					if (fails <= 10)
						$display({"mismatch: expected kind %0d tx %h dist %0d code %0d last %0d,",
							" got kind %0d tx %h dist %0d code %0d last %0d"},
							head.kind, head.tx_byte, head.distance, head.error_code,
							head.last, m_tuser, m_tdata[7:0], m_tdata[38:8],
							m_tdata[41:39], m_tlast);
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = OP_START;
		cfg_we = 1'b0;
		cfg_addr = REG_ATTEMPT_LIMIT;
		cfg_wdata = 16'h0000;
		steady = 1'b0;
		fails = 0;
		live_items = 0;
		n_checked = 0;
		n_dist = 0;
		n_perr = 0;
		n_mism = 0;
		n_busy = 0;
		frames_closed = 0;
		frame_open();
		ph = PH_IDLE;
		tries = 0;
		lim = int'(ATTEMPT_RESET);
		tmo = int'(TIMEOUT_RESET);

		// idle noise, one full sequence with bare replies, then a restart
		dir_tab.push_back(dir_row(OP_SPARE, 8'hFF, 1'b1, 1'b1, K_TX, E_NONE));
		dir_tab.push_back(dir_row(OP_BYTE, CH_GT, 1'b1, 1'b1, K_TX, E_NONE));
		dir_tab.push_back(dir_row(OP_TICK, 8'h00, 1'b1, 1'b1, K_TX, E_NONE));
		dir_tab.push_back(dir_row(OP_START, 8'h00, 1'b0, 1'b0, K_TX, E_NONE));
		dir_tab.push_back(dir_row(OP_START, 8'hFF, 1'b1, 1'b0, K_BUSY, E_NONE));
		dir_tab.push_back(dir_row(OP_BYTE, 8'h00, 1'b0, 1'b0, K_TX, E_NONE));
		dir_tab.push_back(dir_row(OP_BYTE, 8'hFF, 1'b0, 1'b0, K_TX, E_NONE));
		dir_tab.push_back(dir_row(OP_BYTE, CH_GT, 1'b0, 1'b0, K_TX, E_NONE));
		dir_tab.push_back(dir_row(OP_TICK, 8'hFF, 1'b0, 1'b0, K_TX, E_NONE));
		dir_tab.push_back(dir_row(OP_BYTE, CH_GT, 1'b1, 1'b0, K_MISM, E_NONE));
		dir_tab.push_back(dir_row(OP_BYTE, CH_GT, 1'b1, 1'b0, K_MISM, E_NONE));
		dir_tab.push_back(dir_row(OP_BYTE, CH_GT, 1'b1, 1'b0, K_MISM, E_NONE));
		dir_tab.push_back(dir_row(OP_BYTE, CH_LT, 1'b0, 1'b0, K_TX, E_NONE));
		dir_tab.push_back(dir_row(OP_BYTE, CH_0, 1'b0, 1'b0, K_TX, E_NONE));
		dir_tab.push_back(dir_row(OP_BYTE, CH_E, 1'b0, 1'b0, K_TX, E_NONE));
		dir_tab.push_back(dir_row(OP_BYTE, CH_GT, 1'b1, 1'b0, K_PERR, E_DEVICE));
		dir_tab.push_back(dir_row(OP_BYTE, CH_GT, 1'b1, 1'b0, K_MISM, E_NONE));
		dir_tab.push_back(dir_row(OP_BYTE, CH_GT, 1'b1, 1'b0, K_MISM, E_NONE));
		dir_tab.push_back(dir_row(OP_START, 8'h55, 1'b0, 1'b0, K_TX, E_NONE));
		dir_tab.push_back(dir_row(OP_START, 8'hAA, 1'b1, 1'b0, K_BUSY, E_NONE));

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			feed_item(dir_tab[i].op, dir_tab[i].data);
			if (dir_tab[i].typed) begin
				if (dir_tab[i].silent) begin
					while (sequencer_out_q.size() > first_new)
						sequencer_out_q.delete(sequencer_out_q.size() - 1);
				end else begin
					head = sequencer_out_q[first_new];
					head.kind = dir_tab[i].kind;
					head.tx_byte = 8'h00;
					head.distance = 31'd0;
					head.error_code = dir_tab[i].code;
					sequencer_out_q[first_new] = head;
				end
			end
		end
		settle();

		write_reg(REG_ATTEMPT_LIMIT, 16'd0);
		write_reg(REG_TIMEOUT, 16'd1);
		random_phase(40);
		settle();

		steady = 1'b1;
		write_reg(REG_ATTEMPT_LIMIT, 16'd255);
		write_reg(REG_TIMEOUT, 16'd65535);
		random_phase(40);
		settle();
		steady = 1'b0;

		write_reg(REG_ATTEMPT_LIMIT, 16'd3);
		write_reg(REG_TIMEOUT, 16'd3);
		random_phase(40);
		settle();

		write_reg(REG_ATTEMPT_LIMIT, 16'($urandom_range(1, 6)));
		write_reg(REG_TIMEOUT, 16'($urandom_range(1, 6)));
		random_phase(40);
		settle();

		write_reg(REG_ATTEMPT_LIMIT, 16'd2);
		write_reg(REG_TIMEOUT, TIMEOUT_RESET);
		random_phase(40);
		settle();

		if (sequencer_out_q.size() != 0)
			$display("%0d expected results never arrived", sequencer_out_q.size());
		$display("ran %0d input transactions and checked %0d result transactions",
			live_items, n_checked);
		$display("seen: %0d distances, %0d parse errors, %0d reply mismatches, %0d busy rejects",
			n_dist, n_perr, n_mism, n_busy);
		if (fails == 0 && sequencer_out_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
